@@ design/cddc_pkg.sv @@
// Package for the CD data controller register file.
// Holds command codes, register addresses and bit masks; no dependencies.
`default_nettype none
package cddc_pkg;

    typedef enum logic [2:0] {
        CMD_SET_ADDR  = 3'd0,
        CMD_WRITE     = 3'd1,
        CMD_READ      = 3'd2,
        CMD_SECTOR    = 3'd3,
        CMD_HOST_READ = 3'd4,
        CMD_BULK_DONE = 3'd5
    } cmd_t;

    localparam logic [4:0] RA_IFSTAT = 5'h01;
    localparam logic [4:0] RA_DBCL   = 5'h02;
    localparam logic [4:0] RA_DBCH   = 5'h03;
    localparam logic [4:0] RA_R4     = 5'h04;
    localparam logic [4:0] RA_R5     = 5'h05;
    localparam logic [4:0] RA_R6     = 5'h06;
    localparam logic [4:0] RA_R7     = 5'h07;
    localparam logic [4:0] RA_R8     = 5'h08;
    localparam logic [4:0] RA_R9     = 5'h09;
    localparam logic [4:0] RA_RA     = 5'h0A;
    localparam logic [4:0] RA_RB     = 5'h0B;
    localparam logic [4:0] RA_RC     = 5'h0C;
    localparam logic [4:0] RA_RD     = 5'h0D;
    localparam logic [4:0] RA_RE     = 5'h0E;
    localparam logic [4:0] RA_RF     = 5'h0F;

    localparam logic [7:0] DTEI    = 8'h40;
    localparam logic [7:0] DECI    = 8'h20;
    localparam logic [7:0] BUSY_EN = 8'h0A;
    localparam logic [7:0] DOUTEN  = 8'h02;
    localparam logic [7:0] DECEN   = 8'h80;
    localparam logic [7:0] AUTORQ  = 8'h10;
    localparam logic [7:0] WRRQ    = 8'h04;
    localparam logic [7:0] MODRQ   = 8'h08;
    localparam logic [7:0] FORMRQ  = 8'h04;
    localparam logic [7:0] SHDREN  = 8'h01;
    localparam logic [7:0] VALST   = 8'h80;

    localparam logic [2:0] DEST_IDLE  = 3'd0;
    localparam logic [2:0] DEST_HOST0 = 3'd2;
    localparam logic [2:0] DEST_HOST1 = 3'd3;
    localparam logic [2:0] DEST_WAVE  = 3'd4;
    localparam logic [2:0] DEST_PROG  = 3'd5;
    localparam logic [2:0] DEST_BAD   = 3'd6;
    localparam logic [2:0] DEST_WORD  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  value;
        logic [31:0] header;
        logic [31:0] subheader;
        logic [2:0]  transfer_dest;
        logic [15:0] dest_word_addr;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq_request;
        logic [13:0] host_word_addr;
        logic        host_word_valid;
        logic        data_ready;
        logic        transfer_end;
        logic [15:0] dest_word_addr_next;
        logic [13:0] sector_store_offset;
        logic        sector_store_valid;
    } rsp_t;

endpackage
`default_nettype wire

@@ design/cddc_core.sv @@
// Register state and next-state update logic for one request.
// Depends on cddc_pkg.
`default_nettype none
module cddc_core #(
    parameter int BUFFER_BYTES = 16384,
    parameter int SECTOR_BYTES = 2352
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          irq_en,
    input  wire logic          step,
    input  wire cddc_pkg::req_t req,
    output cddc_pkg::rsp_t     rsp
);
    import cddc_pkg::*;

    localparam logic [15:0] BufMask  = 16'(BUFFER_BYTES - 1);
    localparam logic [15:0] WordMask = BufMask & 16'hFFFE;
    localparam logic [15:0] SecLen   = 16'(SECTOR_BYTES);

    logic [4:0]  ra_reg, ra_next;
    logic [7:0]  ifs_reg, ifs_next, ifc_reg, ifc_next;
    logic [15:0] dbc_reg, dbc_next, dac_reg, dac_next, wa_reg, wa_next, pt_reg, pt_next;
    logic [7:0]  c0_reg, c0_next, c1_reg, c1_next;
    logic [7:0]  s0_reg, s0_next, s2_reg, s2_next, s3_reg, s3_next;
    logic [31:0] mh_reg, mh_next, sh_reg, sh_next;
    logic [7:0]  irq_reg, irq_next;
    logic [2:0]  ad_reg, ad_next;
    logic        rdy_reg, rdy_next, end_reg, end_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ra_reg <= '0; ifs_reg <= 8'hFF; ifc_reg <= '0;
            dbc_reg <= '0; dac_reg <= '0; wa_reg <= '0; pt_reg <= '0;
            c0_reg <= '0; c1_reg <= '0; s0_reg <= '0; s2_reg <= '0; s3_reg <= VALST;
            mh_reg <= '0; sh_reg <= '0; irq_reg <= '0; ad_reg <= DEST_IDLE;
            rdy_reg <= 1'b0; end_reg <= 1'b0;
        end else if (step) begin
            ra_reg <= ra_next; ifs_reg <= ifs_next; ifc_reg <= ifc_next;
            dbc_reg <= dbc_next; dac_reg <= dac_next; wa_reg <= wa_next; pt_reg <= pt_next;
            c0_reg <= c0_next; c1_reg <= c1_next; s0_reg <= s0_next; s2_reg <= s2_next;
            s3_reg <= s3_next; mh_reg <= mh_next; sh_reg <= sh_next; irq_reg <= irq_next;
            ad_reg <= ad_next; rdy_reg <= rdy_next; end_reg <= end_next;
        end
    end

    logic [31:0] hd;
    logic [16:0] len;
    logic [15:0] pt_add, dbc_dec;
    logic [7:0]  prev;
    logic        host_act, fin;

    always_comb begin
        ra_next = ra_reg; ifs_next = ifs_reg; ifc_next = ifc_reg;
        dbc_next = dbc_reg; dac_next = dac_reg; wa_next = wa_reg; pt_next = pt_reg;
        c0_next = c0_reg; c1_next = c1_reg; s0_next = s0_reg; s2_next = s2_reg;
        s3_next = s3_reg; mh_next = mh_reg; sh_next = sh_reg; irq_next = irq_reg;
        ad_next = ad_reg; rdy_next = rdy_reg; end_next = end_reg;
        rsp = '0;
        rsp.dest_word_addr_next = req.dest_word_addr;
        prev = irq_reg;
        fin = 1'b0;
        host_act = (ad_reg == DEST_HOST0) || (ad_reg == DEST_HOST1);
        hd = ((c1_reg & SHDREN) != 0) ? sh_reg : mh_reg;
        len = {1'b0, dbc_reg} + 17'd1;
        pt_add = pt_reg + SecLen;
        dbc_dec = dbc_reg - 16'd2;
        case (req.cmd)
            CMD_SET_ADDR: ra_next = req.value[4:0];
            CMD_WRITE, CMD_READ: begin
                if (ra_reg != 5'd0) ra_next = ra_reg + 5'd1;
                if (req.cmd == CMD_WRITE) begin
                    case (ra_reg)
                        RA_IFSTAT: begin
                            irq_next = ~ifs_reg & req.value & (DTEI | DECI);
                            if ((req.value & DOUTEN) == 0) begin
                                ifs_next = ifs_reg | BUSY_EN;
                                ad_next = DEST_IDLE;
                            end
                            ifc_next = req.value;
                        end
                        RA_DBCL: dbc_next[7:0] = req.value;
                        RA_DBCH: dbc_next[15:8] = {4'd0, req.value[3:0]};
                        RA_R4: dac_next[7:0] = req.value;
                        RA_R5: dac_next[15:8] = req.value;
                        RA_R6: begin
                            if ((ifc_reg & DOUTEN) != 0) begin
                                ifs_next = ifs_reg & ~BUSY_EN;
                                rdy_next = 1'b0;
                                end_next = 1'b0;
                                ad_next = req.transfer_dest;
                                if (req.transfer_dest == DEST_HOST0 ||
                                    req.transfer_dest == DEST_HOST1) begin
                                    rsp.host_word_addr = dac_reg[13:0] & WordMask[13:0];
                                    rsp.host_word_valid = 1'b1;
                                    dac_next = dac_reg + 16'd2;
                                    dbc_next = dbc_dec;
                                    rdy_next = 1'b1;
                                end else if (req.transfer_dest < DEST_WAVE ||
                                             req.transfer_dest == DEST_BAD) begin
                                    ad_next = DEST_IDLE;
                                end
                            end
                        end
                        RA_R7: begin
                            ifs_next = ifs_reg | DTEI;
                            irq_next = irq_reg & ~DTEI;
                        end
                        RA_R8: wa_next[7:0] = req.value;
                        RA_R9: wa_next[15:8] = req.value;
                        RA_RA: begin
                            s0_next = req.value & DECEN;
                            if ((req.value & DECEN) == 0) begin
                                ifs_next = ifs_reg | DECI;
                                irq_next = irq_reg & ~DECI;
                            end
                            if ((req.value & AUTORQ) != 0)
                                s2_next = (c1_reg & MODRQ) | {5'd0, sh_reg[21], 2'd0};
                            else
                                s2_next = c1_reg & (MODRQ | FORMRQ);
                            c0_next = req.value;
                        end
                        RA_RB: begin
                            if ((c0_reg & AUTORQ) != 0)
                                s2_next = (req.value & MODRQ) | {5'd0, sh_reg[21], 2'd0};
                            else
                                s2_next = req.value & (MODRQ | FORMRQ);
                            c1_next = req.value;
                        end
                        RA_RC: pt_next[7:0] = req.value;
                        RA_RD: pt_next[15:8] = req.value;
                        RA_RF: begin
                            ifs_next = 8'hFF; ifc_next = '0; c0_next = '0; c1_next = '0;
                            s0_next = '0; s2_next = '0; s3_next = VALST;
                            irq_next = '0; ad_next = DEST_IDLE;
                        end
                        default: ;
                    endcase
                end else begin
                    case (ra_reg)
                        RA_IFSTAT: rsp.read_data = ifs_reg;
                        RA_DBCL: rsp.read_data = dbc_reg[7:0];
                        RA_DBCH: rsp.read_data = dbc_reg[15:8];
                        RA_R4: rsp.read_data = hd[7:0];
                        RA_R5: rsp.read_data = hd[15:8];
                        RA_R6: rsp.read_data = hd[23:16];
                        RA_R7: rsp.read_data = hd[31:24];
                        RA_R8: rsp.read_data = pt_reg[7:0];
                        RA_R9: rsp.read_data = pt_reg[15:8];
                        RA_RA: rsp.read_data = wa_reg[7:0];
                        RA_RB: rsp.read_data = wa_reg[15:8];
                        RA_RC: rsp.read_data = s0_reg;
                        RA_RD: rsp.read_data = 8'h00;
                        RA_RE: rsp.read_data = s2_reg;
                        RA_RF: begin
                            rsp.read_data = s3_reg;
                            s3_next = VALST;
                            ifs_next = ifs_reg | DECI;
                            irq_next = irq_reg & ~DECI;
                        end
                        default: rsp.read_data = 8'hFF;
                    endcase
                end
            end
            CMD_SECTOR: begin
                if ((c0_reg & DECEN) != 0) begin
                    mh_next = req.header;
                    s3_next = '0;
                    ifs_next = ifs_reg & ~DECI;
                    if ((ifc_reg & DECI) != 0 && (irq_reg & DTEI) == 0)
                        irq_next = irq_reg | DECI;
                    if ((c0_reg & WRRQ) != 0) begin
                        pt_next = pt_add;
                        wa_next = wa_reg + SecLen;
                        rsp.sector_store_offset = pt_add[13:0] & BufMask[13:0];
                        rsp.sector_store_valid = 1'b1;
                        if (req.header[31:24] != 8'h01) sh_next = req.subheader;
                    end
                end
            end
            CMD_HOST_READ: begin
                if (host_act) begin
                    if (end_reg) rdy_next = 1'b0;
                    else begin
                        rsp.host_word_addr = dac_reg[13:0] & WordMask[13:0];
                        rsp.host_word_valid = 1'b1;
                        dac_next = dac_reg + 16'd2;
                        dbc_next = dbc_dec;
                        fin = dbc_dec[15];
                    end
                end
            end
            CMD_BULK_DONE: begin
                if (ad_reg >= DEST_WAVE) begin
                    if (ad_reg == DEST_PROG || ad_reg == DEST_WORD)
                        rsp.dest_word_addr_next = req.dest_word_addr + {2'd0, len[16:3]};
                    else if (ad_reg == DEST_WAVE)
                        rsp.dest_word_addr_next = req.dest_word_addr + {1'd0, len[16:2]};
                    dac_next = dac_reg + len[15:0];
                    fin = 1'b1;
                end
            end
            default: ;
        endcase
        if (fin) begin
            dbc_next = 16'hFFFF;
            ifs_next = (ifs_reg | BUSY_EN) & ~DTEI;
            if ((ifc_reg & DTEI) != 0) irq_next = irq_reg | DTEI;
            end_next = 1'b1;
            rdy_next = 1'b0;
            ad_next = DEST_IDLE;
        end
        rsp.irq_request = irq_en && (prev == 8'd0) && (irq_next != 8'd0);
        rsp.data_ready = rdy_next;
        rsp.transfer_end = end_next;
    end
endmodule
`default_nettype wire

@@ design/cd_data_controller_registers.sv @@
// Indirect register file of a CD data controller: one request per clock, a result
// register after the update logic. A new request is accepted every cycle while the result
// register is empty or being drained. Uses cddc_pkg, cddc_core.
`default_nettype none
module cd_data_controller_registers #(
    parameter int BUFFER_BYTES = 16384,
    parameter int SECTOR_BYTES = 2352
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [7:0]  s_value,
    input  wire logic [31:0] s_header,
    input  wire logic [31:0] s_subheader,
    input  wire logic [2:0]  s_transfer_dest,
    input  wire logic [15:0] s_dest_word_addr,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_irq_request,
    output logic [13:0]      m_host_word_addr,
    output logic             m_host_word_valid,
    output logic             m_data_ready,
    output logic             m_transfer_end,
    output logic [15:0]      m_dest_word_addr_next,
    output logic [13:0]      m_sector_store_offset,
    output logic             m_sector_store_valid
);
    import cddc_pkg::*;

    logic   irq_en_reg, mv_reg, step;
    req_t   req;
    rsp_t   rsp, out_reg;

    assign s_ready = !mv_reg || m_ready;
    assign step = s_valid && s_ready;
    assign req = '{cmd: s_cmd, value: s_value, header: s_header, subheader: s_subheader,
                   transfer_dest: s_transfer_dest, dest_word_addr: s_dest_word_addr};

    cddc_core #(.BUFFER_BYTES(BUFFER_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_core (
        .aclk(aclk), .aresetn(aresetn), .irq_en(irq_en_reg), .step(step),
        .req(req), .rsp(rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_en_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (cfg_we) irq_en_reg <= cfg_wdata;
            if (s_ready) mv_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) out_reg <= rsp;
    end

    assign m_valid = mv_reg;
    assign m_read_data = out_reg.read_data;
    assign m_irq_request = out_reg.irq_request;
    assign m_host_word_addr = out_reg.host_word_addr;
    assign m_host_word_valid = out_reg.host_word_valid;
    assign m_data_ready = out_reg.data_ready;
    assign m_transfer_end = out_reg.transfer_end;
    assign m_dest_word_addr_next = out_reg.dest_word_addr_next;
    assign m_sector_store_offset = out_reg.sector_store_offset;
    assign m_sector_store_valid = out_reg.sector_store_valid;
endmodule
`default_nettype wire
